// ----- sv/seven_segment_decimal_scan_driver_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the seven-segment scan driver
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DECIMAL_SCAN_DRIVER_ASSERT_SVH
`define SEVEN_SEGMENT_DECIMAL_SCAN_DRIVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- sv/ssd_pkg.sv -----
// ---------------------------------------------------------------------------
// ssd_pkg
// Shared widths, control structs and the segment encoding table.
// ---------------------------------------------------------------------------
package ssd_pkg;

    localparam int VALUE_W = 27;
    localparam int SEG_W   = 8;
    localparam int SEL_W   = 3;
    localparam int DIGIT_W = 4;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    localparam longint VALUE_MAX = (64'd1 << VALUE_W) - 64'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic start;
    } ssd_conv_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ssd_conv_stat_t;

    // largest value the display shows for n digits
    function automatic logic [VALUE_W-1:0] ssd_sat_limit(input int n);
        longint lim;
        lim = 1;
        for (int k = 0; k < n; k++)
        begin
            lim = lim * 10;
            if (lim > VALUE_MAX + 1)
            begin
                return VALUE_W'(VALUE_MAX);
            end
        end
        return VALUE_W'(lim - 1);
    endfunction

    // decimal digits needed for a limit
    function automatic int ssd_dec_digits(input longint lim);
        int     d;
        longint p;
        d = 1;
        p = 10;
        while (p <= lim)
        begin
            p = p * 10;
            d = d + 1;
        end
        return d;
    endfunction

    function automatic logic [SEG_W-1:0] ssd_seg(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- sv/ssd_dabble.sv -----
// ---------------------------------------------------------------------------
// ssd_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ---------------------------------------------------------------------------
module ssd_dabble #(
    parameter int BCD_DIGITS = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssd_pkg::ssd_conv_req_t                req,
    input  logic [ssd_pkg::VALUE_W-1:0]           value,
    output ssd_pkg::ssd_conv_stat_t               stat,
    output logic [BCD_DIGITS*ssd_pkg::DIGIT_W-1:0] bcd
);
    import ssd_pkg::*;

    localparam int BCD_W = BCD_DIGITS * DIGIT_W;
    localparam int CNT_W = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
            else
            begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

// ----- sv/seven_segment_decimal_scan_driver.sv -----
// ---------------------------------------------------------------------------
// seven_segment_decimal_scan_driver
// Multiplexed seven-segment driver: loads a number as blanked decimal
// segment patterns and scans one digit per tick.
// ---------------------------------------------------------------------------
//  channel  dir  tdata                            tuser
//  s_axis   in   [26:0] value                     kind (0 load, 1 tick)
//  m_axis   out  [7:0] segments, [10:8] select    -
//
//  Tick beat: the scan position steps and the emit state then registers the drive.
//  Load beat: bit-serial shift/add-3 conversion of the 27-bit value, then the
//  digits are taken, one pattern is written per digit and the drive goes into
//  the output register. A held result stalls the emit.
//  One item in flight; s_tready is high whenever idle, even with a result
//  still held on m_axis. Reset blanks all digits and sets scan position 0.
// ---------------------------------------------------------------------------
`include "seven_segment_decimal_scan_driver_assert.svh"

module seven_segment_decimal_scan_driver #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ssd_pkg::S_DATA_W-1:0]   s_tdata,   // [26:0] value
    input  logic                           s_tuser,   // [0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ssd_pkg::M_DATA_W-1:0]   m_tdata    // [7:0] segments, [10:8] digit_select
);
    import ssd_pkg::*;

    localparam logic [VALUE_W-1:0] LIMIT = ssd_sat_limit(DIGIT_COUNT);
    localparam int BCD_DIGITS = ssd_dec_digits(longint'(LIMIT));
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int POS_W      = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CMP_W      = POS_W + 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_WRITE,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   scan_reg, scan_next;
    logic [SEG_W-1:0]   pat_reg [DIGIT_COUNT];
    logic [SEG_W-1:0]   pat_next [DIGIT_COUNT];
    logic [BCD_W-1:0]   bcd_sh_reg, bcd_sh_next;
    logic [POS_W-1:0]   wpos_reg, wpos_next;
    logic               seen_reg, seen_next;
    logic               m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    ssd_conv_req_t      conv_req;
    ssd_conv_stat_t     conv_stat;
    logic [BCD_W-1:0]   conv_bcd;
    logic [VALUE_W-1:0] in_value;
    logic [VALUE_W-1:0] sat_value;
    logic               accept;
    logic [DIGIT_W-1:0] wdigit;
    logic               wdigit_live;
    logic               seen_now;
    logic [POS_W-1:0]   sel_diff;

    assign in_value  = s_tdata[VALUE_W-1:0];
    assign sat_value = (in_value > LIMIT) ? LIMIT : in_value;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign conv_req.start = accept && (s_tuser == KIND_LOAD);

    ssd_dabble #(
        .BCD_DIGITS (BCD_DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .value (sat_value),
        .stat  (conv_stat),
        .bcd   (conv_bcd)
    );

    assign wdigit_live = (CMP_W'(wpos_reg) < CMP_W'(BCD_DIGITS));
    assign wdigit      = wdigit_live ? bcd_sh_reg[BCD_W-1 -: DIGIT_W] : '0;
    assign seen_now    = seen_reg || (wdigit != '0);
    assign sel_diff    = LAST_POS - scan_reg;

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        pat_next     = pat_reg;
        bcd_sh_next  = bcd_sh_reg;
        wpos_next    = wpos_reg;
        seen_next    = seen_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_TICK)
                    begin
                        scan_next  = (scan_reg == LAST_POS) ? '0 : scan_reg + POS_W'(1);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                if (conv_stat.done)
                begin
                    bcd_sh_next = conv_bcd;
                    wpos_next   = LAST_POS;
                    seen_next   = 1'b0;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (wdigit_live)
                begin
                    bcd_sh_next = {bcd_sh_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                end
                seen_next = seen_now;
                pat_next[wpos_reg] = (seen_now || (wpos_reg == '0)) ? ssd_seg(wdigit) : '0;
                if (wpos_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    wpos_next = wpos_reg - POS_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_DATA_W-SEG_W-SEL_W){1'b0}}, SEL_W'(sel_diff),
                                    pat_reg[scan_reg]};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            scan_reg    <= '0;
            wpos_reg    <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                pat_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            wpos_reg    <= wpos_next;
            seen_reg    <= seen_next;
            m_valid_reg <= m_valid_next;
            pat_reg     <= pat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_sh_reg <= bcd_sh_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SSD_ASSERT_NEXT(a_load_blocks, clk, rst_n, accept && (s_tuser == KIND_LOAD), !s_tready, "load beat did not start conversion")
    `SSD_ASSERT_NEXT(a_tick_emits, clk, rst_n, accept && (s_tuser == KIND_TICK), state_reg == ST_EMIT, "tick beat did not go to emit")
    `SSD_ASSERT_SAME(a_done_in_conv, clk, rst_n, conv_stat.done, state_reg == ST_CONV, "conversion finished outside conversion state")
    `SSD_ASSERT_SAME(a_scan_range, clk, rst_n, 1'b1, CMP_W'(scan_reg) < CMP_W'(DIGIT_COUNT), "scan position out of range")

endmodule

// ----- verif/scan_drive_checker.sv -----
// ---------------------------------------------------------------------------
// scan_drive_checker
// Watches both stream channels of the seven-segment scan driver. It keeps
// its own copy of the digit store and the scan position, predicts the
// segment and select drive for every accepted input beat, and compares
// each output beat in order against the oldest prediction.
// ---------------------------------------------------------------------------
module scan_drive_checker #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [ssd_pkg::S_DATA_W-1:0] s_tdata,    // [26:0] value
    input  logic                         s_tuser,    // [0] kind
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ssd_pkg::M_DATA_W-1:0] m_tdata,    // [7:0] segments, [10:8] digit_select
    output int                           mismatch_count,
    output int                           pending_count,
    output int                           checked_count
);

    import ssd_pkg::*;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] digit_select;
    } drive_t;

    localparam longint DECIMAL_SPAN = 64'd10 ** DIGIT_COUNT;
    localparam longint SHOW_LIMIT   = (DECIMAL_SPAN - 1 > VALUE_MAX) ? VALUE_MAX
                                                                   : DECIMAL_SPAN - 1;

    logic [SEG_W-1:0] shown_digits [DIGIT_COUNT];
    int               scan_pos;
    drive_t           drive_queue [$];

    function automatic logic [SEG_W-1:0] glyph(input int d);
        case (d)
            0:       return 8'h3F;
            1:       return 8'h06;
            2:       return 8'h5B;
            3:       return 8'h4F;
            4:       return 8'h66;
            5:       return 8'h6D;
            6:       return 8'h7D;
            7:       return 8'h07;
            8:       return 8'h7F;
            default: return 8'h6F;
        endcase
    endfunction

    // update the digit store / scan position, then queue the resulting drive
    task automatic predict_drive(input logic kind, input logic [VALUE_W-1:0] value);
        longint rest;
        drive_t want;
        if (kind == KIND_LOAD)
        begin
            rest = (longint'(value) > SHOW_LIMIT) ? SHOW_LIMIT : longint'(value);
            for (int p = 0; p < DIGIT_COUNT; p++)
            begin
                // leading zeros blank, but zero itself shows one 0
                if (rest != 0 || p == 0)
                begin
                    shown_digits[p] = glyph(int'(rest % 10));
                end
                else
                begin
                    shown_digits[p] = '0;
                end
                rest = rest / 10;
            end
        end
        else
        begin
            scan_pos = (scan_pos + 1 >= DIGIT_COUNT) ? 0 : scan_pos + 1;
        end
        want.segments     = shown_digits[scan_pos];
        want.digit_select = SEL_W'(DIGIT_COUNT - 1 - scan_pos);
        drive_queue.push_back(want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        drive_t got;
        drive_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < DIGIT_COUNT; p++)
            begin
                shown_digits[p] = '0;
            end
            scan_pos       = 0;
            drive_queue.delete();
            mismatch_count = 0;
            pending_count  = 0;
            checked_count  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.segments     = m_tdata[SEG_W-1:0];
                got.digit_select = m_tdata[SEG_W +: SEL_W];
                checked_count++;
                if (drive_queue.size() == 0)
                begin
                    $error("output beat with nothing expected: segments %02h, digit_select %0d",
                           got.segments, got.digit_select);
                    mismatch_count++;
                end
                else
                begin
                    want = drive_queue.pop_front();
                    if (got.segments !== want.segments)
                    begin
                        $error("segments: expected %02h, actual %02h",
                               want.segments, got.segments);
                        mismatch_count++;
                    end
                    if (got.digit_select !== want.digit_select)
                    begin
                        $error("digit_select: expected %0d, actual %0d",
                               want.digit_select, got.digit_select);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_drive(s_tuser, s_tdata[VALUE_W-1:0]);
            end
            pending_count = drive_queue.size();
        end
    end

endmodule

// ----- verif/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the seven-segment scan driver. Directed loads
// and ticks cover zero, single digits, inner zeros, the largest shown value
// and saturation, and a full scan wrap; random loads and tick sweeps follow
// with random idling on both channels. Checking is done by scan_drive_checker.
// ---------------------------------------------------------------------------
module tb;

    import ssd_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;     // [26:0] value
    logic                s_tuser;     // [0] kind
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;     // [7:0] segments, [10:8] digit_select

    int mismatch_count;
    int pending_count;
    int checked_count;
    int load_beats;
    int tick_beats;
    int clipped_loads;
    int sent_beats;
    bit drain;

    localparam int RANDOM_BEATS = 730;
    localparam int CALM_FROM    = 640;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    seven_segment_decimal_scan_driver i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scan_drive_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    // random idle burst ahead of a beat
    task automatic maybe_idle();
        if (!drain && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_beat(input logic kind, input logic [VALUE_W-1:0] value);
        maybe_idle();
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'(value);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent_beats++;
        if (kind == KIND_LOAD)
        begin
            load_beats++;
            if (value > 99999999)
            begin
                clipped_loads++;
            end
        end
        else
        begin
            tick_beats++;
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return VALUE_W'($urandom_range(0, 99));
            1:       return VALUE_W'($urandom_range(0, 99999));
            2:       return VALUE_W'($urandom_range(0, 99999999));
            3:       return VALUE_W'($urandom_range(100000000, 134217727));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!drain && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= KIND_LOAD;
        drain         = 1'b0;
        load_beats    = 0;
        tick_beats    = 0;
        clipped_loads = 0;
        sent_beats    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(KIND_TICK, VALUE_W'(0));            // blank store after reset
        send_beat(KIND_LOAD, VALUE_W'(0));            // zero at position 1: blank
        send_beat(KIND_TICK, VALUE_W'(VALUE_MAX));    // value ignored on tick
        for (int k = 0; k < 6; k++)
        begin
            send_beat(KIND_TICK, VALUE_W'(0));        // wraps back to position 0
        end
        send_beat(KIND_LOAD, VALUE_W'(0));            // single 0 shown
        send_beat(KIND_LOAD, VALUE_W'(99999999));
        send_beat(KIND_LOAD, VALUE_W'(100000000));    // saturates
        send_beat(KIND_LOAD, VALUE_W'(VALUE_MAX));    // saturates
        send_beat(KIND_LOAD, VALUE_W'(1));
        send_beat(KIND_LOAD, VALUE_W'(10000000));
        send_beat(KIND_LOAD, VALUE_W'(12345678));
        for (int k = 0; k < 8; k++)
        begin
            send_beat(KIND_TICK, VALUE_W'($urandom));
        end
        send_beat(KIND_LOAD, VALUE_W'(90807));        // inner zeros

        while (sent_beats < RANDOM_BEATS)
        begin
            if (sent_beats >= CALM_FROM)
            begin
                drain = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                // load then sweep every position
                send_beat(KIND_LOAD, pick_value());
                for (int k = 0; k < 8; k++)
                begin
                    send_beat(KIND_TICK, VALUE_W'($urandom));
                end
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                send_beat(KIND_LOAD, pick_value());
            end
            else
            begin
                send_beat(KIND_TICK, VALUE_W'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 4000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (64) @(posedge clk);
        if (pending_count != 0)
        begin
            $error("%0d expected drive beats never arrived", pending_count);
        end

        $display("covered %0d beats: %0d loads (%0d above display range), %0d scan ticks",
                 sent_beats, load_beats, clipped_loads, tick_beats);
        $display("checked %0d output beats, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("timeout waiting on the scan driver");
        $display("status: fail");
        $finish;
    end

endmodule
